/* hw/rtl/cau_pkg.sv */
// cau_pkg: widths, operation and status codes, pipeline structs and helper
// functions for the complex arithmetic unit
// no dependencies
`default_nettype none

package cau_pkg;

	localparam int DW        = 16;             // operand and result part width
	localparam int FRAC_BITS = 8;              // fraction bits of the fixed-point format
	localparam int PW        = 2 * DW;         // product width
	localparam int SW        = PW + 1;         // sum of two products
	localparam int DENW      = SW;             // |b|^2 width
	localparam int QB        = DW;             // quotient bits resolved by the divider
	localparam int NW        = DENW + QB;      // dividend / remainder width
	localparam int DIV_LAT   = QB + 1;         // divider stages
	localparam int HALF      = (1 << FRAC_BITS) >> 1;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_CMP = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_SAT = 2'd1,
		ST_DZ  = 2'd2
	} status_t;

	// beat leaving the front end (after the sums of products)
	typedef struct packed {
		logic [2:0]       op;
		logic signed [DW:0] add_re;
		logic signed [DW:0] add_im;
		logic signed [DW:0] sub_re;
		logic signed [DW:0] sub_im;
		logic             eq;
		logic signed [SW-1:0] mul_re;
		logic signed [SW-1:0] mul_im;
		logic signed [SW-1:0] num_re;
		logic signed [SW-1:0] num_im;
		logic [DENW-1:0]  den;
	} front_t;

	// beat riding beside the divider
	typedef struct packed {
		logic [2:0]    op;
		logic [DW-1:0] re;
		logic [DW-1:0] im;
		logic          eq;
		logic          sat;
		logic          dz;
		logic          neg_re;
		logic          neg_im;
	} side_t;

	function automatic logic signed [SW-1:0] sx_prod(input logic signed [PW-1:0] v);
		return {v[PW-1], v};
	endfunction

	// clip to 16 bits, msb of the result flags a clip
	function automatic logic [DW:0] sat_w(input logic signed [SW-1:0] v);
		if (v > $signed(SW'(32767))) begin
			return {1'b1, 16'h7fff};
		end else if (v < -$signed(SW'(32768))) begin
			return {1'b1, 16'h8000};
		end else begin
			return {1'b0, v[DW-1:0]};
		end
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/cau_front.sv */
// cau_front: add, subtract, compare, products (stage 1); sums of products (stage 2)
// depends on cau_pkg
`default_nettype none

module cau_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic [2:0]                 operation,
	input  wire logic signed [15:0]         a_re,
	input  wire logic signed [15:0]         a_im,
	input  wire logic signed [15:0]         b_re,
	input  wire logic signed [15:0]         b_im,
	output logic                            out_valid,
	output cau_pkg::front_t                 out_beat
);
	import cau_pkg::*;

	logic                 valid_s1, valid_s2;
	logic [2:0]           op_s1;
	logic signed [DW:0]   add_re_s1, add_im_s1, sub_re_s1, sub_im_s1;
	logic                 eq_s1;
	logic signed [PW-1:0] p_rr_s1, p_ii_s1, p_ir_s1, p_ri_s1, p_bb_re_s1, p_bb_im_s1;
	front_t               beat_s2;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// stage 1: add, subtract, compare and the six products
	always_ff @(posedge clk) begin
		op_s1      <= operation;
		add_re_s1  <= {a_re[DW-1], a_re} + {b_re[DW-1], b_re};
		add_im_s1  <= {a_im[DW-1], a_im} + {b_im[DW-1], b_im};
		sub_re_s1  <= {a_re[DW-1], a_re} - {b_re[DW-1], b_re};
		sub_im_s1  <= {a_im[DW-1], a_im} - {b_im[DW-1], b_im};
		eq_s1      <= (a_re == b_re) && (a_im == b_im);
		p_rr_s1    <= a_re * b_re;
		p_ii_s1    <= a_im * b_im;
		p_ir_s1    <= a_im * b_re;
		p_ri_s1    <= a_re * b_im;
		p_bb_re_s1 <= b_re * b_re;
		p_bb_im_s1 <= b_im * b_im;
	end

	// stage 2: sums of products
	always_ff @(posedge clk) begin
		beat_s2.op     <= op_s1;
		beat_s2.add_re <= add_re_s1;
		beat_s2.add_im <= add_im_s1;
		beat_s2.sub_re <= sub_re_s1;
		beat_s2.sub_im <= sub_im_s1;
		beat_s2.eq     <= eq_s1;
		beat_s2.mul_re <= sx_prod(p_rr_s1) - sx_prod(p_ii_s1);
		beat_s2.mul_im <= sx_prod(p_ir_s1) + sx_prod(p_ri_s1);
		beat_s2.num_re <= sx_prod(p_rr_s1) + sx_prod(p_ii_s1);
		beat_s2.num_im <= sx_prod(p_ir_s1) - sx_prod(p_ri_s1);
		beat_s2.den    <= {1'b0, p_bb_re_s1} + {1'b0, p_bb_im_s1};
	end

	assign out_valid = valid_s2;
	assign out_beat  = beat_s2;

endmodule

`default_nettype wire

/* hw/rtl/cau_div.sv */
// cau_div: pipelined restoring divider, one quotient bit per stage, with overflow flag
// depends on cau_pkg
`default_nettype none

module cau_div (
	input  wire logic                        clk,
	input  wire logic [cau_pkg::NW-1:0]      num,
	input  wire logic [cau_pkg::DENW-1:0]    den,
	output logic [cau_pkg::QB-1:0]           quo,
	output logic                             ovf
);
	import cau_pkg::*;

	logic [NW-1:0]   rem_s [0:QB];
	logic [DENW-1:0] den_s [0:QB];
	logic [QB-1:0]   quo_s [0:QB];
	logic            ovf_s [0:QB];

	// first stage: quotient too large for QB bits
	always_ff @(posedge clk) begin
		rem_s[0] <= num;
		den_s[0] <= den;
		quo_s[0] <= '0;
		ovf_s[0] <= num >= ({{(NW-DENW){1'b0}}, den} << QB);
	end

	// one compare and subtract per stage, msb first
	for (genvar i = 0; i < QB; i++) begin : g_stage
		logic [NW-1:0] dsh;
		logic          ge;
		assign dsh = {{(NW-DENW){1'b0}}, den_s[i]} << (QB - 1 - i);
		assign ge  = rem_s[i] >= dsh;
		always_ff @(posedge clk) begin
			rem_s[i+1] <= ge ? rem_s[i] - dsh : rem_s[i];
			den_s[i+1] <= den_s[i];
			quo_s[i+1] <= {quo_s[i][QB-2:0], ge};
			ovf_s[i+1] <= ovf_s[i];
		end
	end

	assign quo = quo_s[QB];
	assign ovf = ovf_s[QB];

endmodule

`default_nettype wire

/* hw/rtl/complex_arithmetic_unit.sv */
// complex_arithmetic_unit: top level, rounding and saturation, divider operand prep
// depends on cau_pkg, cau_front, cau_div
`default_nettype none

// Complex ALU on signed Q8.8 parts: add, subtract, multiply, divide, compare equal.
// Input channel: an operation beat is taken at a rising edge with start high and
// busy low. busy is always low, so a new beat may enter in every cycle.
// Output channel: done is high for one cycle with res_re, res_im, is_equal and
// status; the receiver takes the beat at the edge ending that cycle and cannot
// stall, so nothing is held back.
// Every operation takes the same path: products, then sums of products, then
// rounding and divider operand prep, then the divider pipeline (an overflow stage
// and one quotient bit per stage), then one output register.
// Throughput is one beat per cycle; results leave in entry order.
// Multiply rounds half up, divide rounds half away from zero; clipped parts set
// status saturated, a zero divisor gives zero parts and status divide by zero.
// Unused operation codes give all-zero results.
// Reset clears every valid bit; beats in flight are dropped.

module complex_arithmetic_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         operation,
	input  wire logic signed [15:0] a_re,
	input  wire logic signed [15:0] a_im,
	input  wire logic signed [15:0] b_re,
	input  wire logic signed [15:0] b_im,
	output logic                    done,
	output logic signed [15:0]      res_re,
	output logic signed [15:0]      res_im,
	output logic                    is_equal,
	output logic [1:0]              status
);
	import cau_pkg::*;

	logic          f_valid;
	front_t        f;

	logic          valid_s3;
	side_t         side_s3;
	logic [NW-1:0] n_re_s3, n_im_s3;
	logic [DENW-1:0] d_s3;

	logic          pipe_valid_q [0:DIV_LAT-1];
	side_t         pipe_side_q  [0:DIV_LAT-1];

	logic [QB-1:0] q_re, q_im;
	logic          ovf_re, ovf_im;

	logic          done_q, eq_q;
	logic [DW-1:0] re_q, im_q;
	logic [1:0]    status_q;

	assign busy = 1'b0;

	cau_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.operation (operation),
		.a_re      (a_re),
		.a_im      (a_im),
		.b_re      (b_re),
		.b_im      (b_im),
		.out_valid (f_valid),
		.out_beat  (f)
	);

	// stage 3 combinational: saturation, multiply rounding, divider operands
	logic [DW:0]   sat_re, sat_im;
	logic signed [SW-1:0] rnd_re, rnd_im;
	logic          nre, nim;
	logic [SW-1:0] neg_num_re, neg_num_im;
	logic [PW-1:0] mag_re, mag_im;
	side_t         side_c;

	always_comb begin
		rnd_re = (f.mul_re + SW'(HALF)) >>> FRAC_BITS;
		rnd_im = (f.mul_im + SW'(HALF)) >>> FRAC_BITS;
		case (f.op)
			OP_ADD: begin
				sat_re = sat_w({{(SW-DW-1){f.add_re[DW]}}, f.add_re});
				sat_im = sat_w({{(SW-DW-1){f.add_im[DW]}}, f.add_im});
			end
			OP_SUB: begin
				sat_re = sat_w({{(SW-DW-1){f.sub_re[DW]}}, f.sub_re});
				sat_im = sat_w({{(SW-DW-1){f.sub_im[DW]}}, f.sub_im});
			end
			OP_MUL: begin
				sat_re = sat_w(rnd_re);
				sat_im = sat_w(rnd_im);
			end
			default: begin
				sat_re = '0;
				sat_im = '0;
			end
		endcase
		nre        = f.num_re[SW-1];
		nim        = f.num_im[SW-1];
		neg_num_re = -f.num_re;
		neg_num_im = -f.num_im;
		mag_re     = nre ? neg_num_re[PW-1:0] : f.num_re[PW-1:0];
		mag_im     = nim ? neg_num_im[PW-1:0] : f.num_im[PW-1:0];
		side_c.op     = f.op;
		side_c.re     = sat_re[DW-1:0];
		side_c.im     = sat_im[DW-1:0];
		side_c.eq     = (f.op == OP_CMP) && f.eq;
		side_c.sat    = sat_re[DW] || sat_im[DW];
		side_c.dz     = (f.den == '0);
		side_c.neg_re = nre;
		side_c.neg_im = nim;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= f_valid;
		end
	end

	// dividend is |num| * 2^(FRAC_BITS+1) + den, divisor 2*den
	always_ff @(posedge clk) begin
		side_s3 <= side_c;
		n_re_s3 <= ({{(NW-PW){1'b0}}, mag_re} << (FRAC_BITS + 1)) + {{(NW-DENW){1'b0}}, f.den};
		n_im_s3 <= ({{(NW-PW){1'b0}}, mag_im} << (FRAC_BITS + 1)) + {{(NW-DENW){1'b0}}, f.den};
		d_s3    <= {f.den[DENW-2:0], 1'b0};
	end

	cau_div u_div_re (
		.clk (clk),
		.num (n_re_s3),
		.den (d_s3),
		.quo (q_re),
		.ovf (ovf_re)
	);

	cau_div u_div_im (
		.clk (clk),
		.num (n_im_s3),
		.den (d_s3),
		.quo (q_im),
		.ovf (ovf_im)
	);

	// side line matching the divider depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) begin
				pipe_valid_q[i] <= 1'b0;
			end
		end else begin
			pipe_valid_q[0] <= valid_s3;
			for (int i = 1; i < DIV_LAT; i++) begin
				pipe_valid_q[i] <= pipe_valid_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		pipe_side_q[0] <= side_s3;
		for (int i = 1; i < DIV_LAT; i++) begin
			pipe_side_q[i] <= pipe_side_q[i-1];
		end
	end

	// quotient sign and saturation
	side_t         sd;
	logic          clip_re, clip_im;
	logic [DW-1:0] dv_re, dv_im;
	logic [DW-1:0] fin_re, fin_im;
	logic [1:0]    fin_st;

	always_comb begin
		sd = pipe_side_q[DIV_LAT-1];
		if (sd.neg_re) begin
			clip_re = ovf_re || (q_re[QB-1] && (q_re[QB-2:0] != '0));
			dv_re   = clip_re ? 16'h8000 : -q_re;
		end else begin
			clip_re = ovf_re || q_re[QB-1];
			dv_re   = clip_re ? 16'h7fff : q_re;
		end
		if (sd.neg_im) begin
			clip_im = ovf_im || (q_im[QB-1] && (q_im[QB-2:0] != '0));
			dv_im   = clip_im ? 16'h8000 : -q_im;
		end else begin
			clip_im = ovf_im || q_im[QB-1];
			dv_im   = clip_im ? 16'h7fff : q_im;
		end
		if (sd.op == OP_DIV) begin
			if (sd.dz) begin
				fin_re = '0;
				fin_im = '0;
				fin_st = ST_DZ;
			end else begin
				fin_re = dv_re;
				fin_im = dv_im;
				fin_st = (clip_re || clip_im) ? ST_SAT : ST_OK;
			end
		end else begin
			fin_re = sd.re;
			fin_im = sd.im;
			fin_st = sd.sat ? ST_SAT : ST_OK;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= pipe_valid_q[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		re_q     <= fin_re;
		im_q     <= fin_im;
		eq_q     <= sd.eq;
		status_q <= fin_st;
	end

	assign done     = done_q;
	assign res_re   = re_q;
	assign res_im   = im_q;
	assign is_equal = eq_q;
	assign status   = status_q;

	// every beat accepted out of reset, and only such a beat, raises done after the full pipeline
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n, 21) |-> (done == $past(start && !busy, 21)))
		else $error("result strobe does not match accepted beat");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_DZ) |-> (res_re == 16'h0 && res_im == 16'h0))
		else $error("divide by zero with nonzero parts");

	a_eq_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_equal) |-> (status == ST_OK && res_re == 16'h0 && res_im == 16'h0))
		else $error("compare result carries parts or status");

endmodule

`default_nettype wire

/* sim/complex_arithmetic_unit_test.sv */
// complex_arithmetic_unit_test: self-checking bench for the complex arithmetic unit
// drives operation beats with random gaps, predicts each result and compares in order
// depends on cau_pkg and complex_arithmetic_unit
`timescale 1ns / 1ps

module complex_arithmetic_unit_test;
	import cau_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int RANDOM_BEATS   = 1100;

	typedef struct packed {
		logic [15:0] re;
		logic [15:0] im;
		logic        eq;
		logic [1:0]  st;
	} cplx_result_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] ar;
		logic [15:0] ai;
		logic [15:0] br;
		logic [15:0] bi;
		logic        known;
		cplx_result_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [2:0] operation;
	logic signed [15:0] a_re, a_im, b_re, b_im;
	logic done;
	logic signed [15:0] res_re, res_im;
	logic is_equal;
	logic [1:0] status;

	cplx_result_t expected_results[$];
	int fail_count;
	int idle_cycles;
	bit stim_done;

	complex_arithmetic_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
		.done(done), .res_re(res_re), .res_im(res_im), .is_equal(is_equal),
		.status(status)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// clip to 16 bits, flag a clip
	function automatic longint clip16(input longint v, inout bit clipped);
		if (v > 32767) begin
			clipped = 1;
			return 32767;
		end
		if (v < -32768) begin
			clipped = 1;
			return -32768;
		end
		return v;
	endfunction

	// nearest, halves away from zero; den > 0
	function automatic longint quot_round(input longint num, input longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag * (64'sd1 << FRAC_BITS) * 2 + den) / (2 * den);
		return (num < 0) ? -q : q;
	endfunction

	// expected result of one operation beat
	function automatic cplx_result_t complex_result(input logic [2:0] op,
			input logic signed [15:0] ar, input logic signed [15:0] ai,
			input logic signed [15:0] br, input logic signed [15:0] bi);
		cplx_result_t r;
		longint xr, xi, yr, yi, rr, ri, den;
		bit clipped;
		xr = ar; xi = ai; yr = br; yi = bi;
		rr = 0; ri = 0; clipped = 0;
		r = '0;
		case (op)
			OP_ADD: begin
				rr = clip16(xr + yr, clipped);
				ri = clip16(xi + yi, clipped);
			end
			OP_SUB: begin
				rr = clip16(xr - yr, clipped);
				ri = clip16(xi - yi, clipped);
			end
			OP_MUL: begin
				// arithmetic shift of a longint floors
				rr = clip16((xr * yr - xi * yi + HALF) >>> FRAC_BITS, clipped);
				ri = clip16((xi * yr + xr * yi + HALF) >>> FRAC_BITS, clipped);
			end
			OP_DIV: begin
				den = yr * yr + yi * yi;
				if (den == 0) begin
					r.st = ST_DZ;
				end else begin
					rr = clip16(quot_round(xr * yr + xi * yi, den), clipped);
					ri = clip16(quot_round(xi * yr - xr * yi, den), clipped);
				end
			end
			OP_CMP: begin
				r.eq = (ar == br) && (ai == bi);
			end
			default: begin
			end
		endcase
		if (clipped) begin
			r.st = ST_SAT;
		end
		r.re = rr[15:0];
		r.im = ri[15:0];
		return r;
	endfunction

	// random operand: mostly wide, some near the edges or small
	function automatic logic [15:0] rand_part();
		case ($urandom_range(0, 9))
			0: return 16'h8000 + 16'($urandom_range(0, 3));
			1: return 16'h7fff - 16'($urandom_range(0, 3));
			2: return 16'($urandom_range(0, 1023)) - 16'd512;
			3: return '0;
			default: return 16'($urandom());
		endcase
	endfunction

	// random gap before a beat: mostly none or short, a few long
	task automatic idle_gap();
		int n;
		case ($urandom_range(0, 19))
			0: n = $urandom_range(10, 40);
			1, 2, 3, 4, 5: n = $urandom_range(1, 3);
			default: n = 0;
		endcase
		repeat (n) begin
			@(posedge clk);
			start <= 1'b0;
		end
	endtask

	// present one beat and wait for it to be taken
	task automatic send_beat(input stim_row_t row);
		cplx_result_t e;
		@(posedge clk);
		start     <= 1'b1;
		operation <= row.op;
		a_re      <= row.ar;
		a_im      <= row.ai;
		b_re      <= row.br;
		b_im      <= row.bi;
		e = complex_result(row.op, row.ar, row.ai, row.br, row.bi);
		if (row.known && e !== row.res) begin
			$display("%0t predictor disagrees with table: expected %h actual %h",
				$time, row.res, e);
			fail_count++;
		end
		do @(negedge clk); while (busy);
		expected_results.push_back(row.known ? row.res : e);
	endtask

	// result checking at the edge that ends the done cycle
	always @(posedge clk) begin
		cplx_result_t e;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t unexpected result: actual re %h im %h eq %b st %0d",
					$time, res_re, res_im, is_equal, status);
				fail_count++;
			end else begin
				e = expected_results.pop_front();
				if (res_re !== e.re) begin
					$display("%0t res_re: expected %h actual %h", $time, e.re, res_re);
					fail_count++;
				end
				if (res_im !== e.im) begin
					$display("%0t res_im: expected %h actual %h", $time, e.im, res_im);
					fail_count++;
				end
				if (is_equal !== e.eq) begin
					$display("%0t is_equal: expected %b actual %b", $time, e.eq, is_equal);
					fail_count++;
				end
				if (status !== e.st) begin
					$display("%0t status: expected %0d actual %0d", $time, e.st, status);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles with no beat moving either way
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// directed table then random beats
	initial begin
		stim_row_t table_rows[$];
		stim_row_t row;
		int i;
		start = 1'b0;
		operation = '0;
		a_re = '0; a_im = '0; b_re = '0; b_im = '0;
		fail_count = 0;
		stim_done = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// {op, ar, ai, br, bi, known, {re, im, eq, st}}
		table_rows = '{
			'{OP_ADD, 16'h0100, 16'h0200, 16'h0300, 16'hff00, 1, '{16'h0400, 16'h0100, 0, ST_OK}},
			'{OP_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1, '{16'h7fff, 16'h8000, 0, ST_SAT}},
			'{OP_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff, 1, '{16'h8000, 16'h7fff, 0, ST_SAT}},
			'{OP_SUB, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 1, '{16'h7fff, 16'h0000, 0, ST_SAT}},
			'{OP_MUL, 16'h0100, 16'h0000, 16'h0100, 16'h0000, 1, '{16'h0100, 16'h0000, 0, ST_OK}},
			'{OP_MUL, 16'h0000, 16'h0100, 16'h0000, 16'h0100, 1, '{16'hff00, 16'h0000, 0, ST_OK}},
			'{OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1, '{16'h0000, 16'h7fff, 0, ST_SAT}},
			'{OP_MUL, 16'h0001, 16'h0000, 16'h0080, 16'h0000, 0, '0},
			'{OP_MUL, 16'hffff, 16'h0000, 16'h0080, 16'h0000, 0, '0},
			'{OP_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 0, '0},
			'{OP_DIV, 16'h0100, 16'h0100, 16'h0000, 16'h0000, 1, '{16'h0000, 16'h0000, 0, ST_DZ}},
			'{OP_DIV, 16'h0200, 16'h0000, 16'h0100, 16'h0000, 1, '{16'h0200, 16'h0000, 0, ST_OK}},
			'{OP_DIV, 16'h7fff, 16'h0000, 16'h0001, 16'h0000, 1, '{16'h7fff, 16'h0000, 0, ST_SAT}},
			'{OP_DIV, 16'h0100, 16'h0000, 16'h0300, 16'h0000, 0, '0},
			'{OP_DIV, 16'h0001, 16'h0000, 16'h0200, 16'h0000, 0, '0},
			'{OP_DIV, 16'hffff, 16'h0000, 16'h0200, 16'h0000, 0, '0},
			'{OP_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, '0},
			'{OP_DIV, 16'h1234, 16'hfedc, 16'h0000, 16'h8000, 0, '0},
			'{OP_CMP, 16'h1234, 16'h5678, 16'h1234, 16'h5678, 1, '{16'h0000, 16'h0000, 1, ST_OK}},
			'{OP_CMP, 16'h1234, 16'h5678, 16'h1234, 16'h5679, 1, '{16'h0000, 16'h0000, 0, ST_OK}},
			'{OP_CMP, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 1, '{16'h0000, 16'h0000, 0, ST_OK}},
			'{3'd5, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1, '{16'h0000, 16'h0000, 0, ST_OK}},
			'{3'd6, 16'h8000, 16'h0001, 16'h0000, 16'h0000, 1, '{16'h0000, 16'h0000, 0, ST_OK}},
			'{3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1, '{16'h0000, 16'h0000, 0, ST_OK}}
		};
		foreach (table_rows[k]) begin
			send_beat(table_rows[k]);
		end

		for (i = 0; i < RANDOM_BEATS; i++) begin
			if (i >= 300 || ($urandom_range(0, 1) == 1)) begin
				idle_gap();
			end
			row = '0;
			row.op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			row.ar = rand_part();
			row.ai = rand_part();
			row.br = rand_part();
			row.bi = rand_part();
			// compare hits and zero divisors need help to show up
			if (row.op == OP_CMP && $urandom_range(0, 1) == 1) begin
				row.br = row.ar;
				row.bi = $urandom_range(0, 2) == 0 ? row.ai ^ 16'h0001 : row.ai;
			end
			if (row.op == OP_DIV && $urandom_range(0, 9) == 0) begin
				row.br = '0;
				row.bi = '0;
			end
			send_beat(row);
		end
		@(posedge clk);
		start <= 1'b0;
		stim_done = 1;
	end

	// end of run: drain, settle, report
	initial begin
		wait (stim_done);
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
